// File: sv/bcdcpf_pkg.sv
// ----------------------------------------------------------------------------
// bcdcpf_pkg
// Shared types, constants and helper functions for the BCD clock pixel frame.
// ----------------------------------------------------------------------------
package bcdcpf_pkg;

	localparam int unsigned PIXELS    = 28;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned COLOUR_W  = 24;
	localparam int unsigned TIME_W    = 32;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

	// register indexes of the configuration port
	localparam logic CFG_DIGIT_COLOUR = 1'b0;
	localparam logic CFG_COLON_COLOUR = 1'b1;

	// request kinds carried in tuser
	localparam logic REQ_SHOW   = 1'b0;
	localparam logic REQ_REDRAW = 1'b1;

	localparam int unsigned DAY_SECS  = 86400;
	localparam int unsigned HOUR_SECS = 3600;
	localparam int unsigned MIN_SECS  = 60;

	// divide by reciprocal multiplication: q = ((x >> pre) * RECIP) >> post
	//   day:  86400 = 675 << 7, x < 2^32,  post 35
	//   hour:  3600 = 225 << 4, x < 86400, post 21
	//   min:     60 =  15 << 2, x < 3600,  post 14
	// each reciprocal is rounded up and exact over its input range
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;
	localparam logic [13:0] HOUR_RECIP = 14'd9321;
	localparam logic [10:0] MIN_RECIP  = 11'd1093;

	typedef struct packed {
		logic [3:0] h_tens;
		logic [3:0] h_units;
		logic [3:0] m_tens;
		logic [3:0] m_units;
		logic [3:0] s_tens;
		logic [3:0] s_units;
	} digits_t;

	typedef struct packed {
		logic colon;
		logic lit;
	} pix_kind_t;

	// split a value below 60 into tens and units; x*205>>11 is x/10 for x < 1029
	function automatic logic [7:0] to_bcd(input logic [5:0] v);
		logic [13:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [6:0]  units;
		prod     = 14'(v) * 14'd205;
		tens     = prod[14-1:11] & 4'hF;
		tens_x10 = 7'(tens) * 7'd10;
		units    = 7'(v) - tens_x10;
		return {tens, units[3:0]};
	endfunction

	// which digit bit (or colon) a strip position shows, in snaking order
	function automatic pix_kind_t pixel_kind(input logic [IDX_W-1:0] pos, input digits_t d);
		pix_kind_t  k;
		logic [IDX_W-1:0] off;
		k   = '0;
		off = '0;
		case (pos) inside
			[5'd0:5'd3]: begin
				off   = pos;
				k.lit = d.h_tens[off[1:0]];
			end
			[5'd4:5'd7]: begin
				off   = 5'd7 - pos;
				k.lit = d.h_units[off[1:0]];
			end
			[5'd10:5'd13]: begin
				off   = 5'd13 - pos;
				k.lit = d.m_tens[off[1:0]];
			end
			[5'd14:5'd17]: begin
				off   = pos - 5'd14;
				k.lit = d.m_units[off[1:0]];
			end
			[5'd20:5'd23]: begin
				off   = pos - 5'd20;
				k.lit = d.s_tens[off[1:0]];
			end
			[5'd24:5'd27]: begin
				off   = 5'd27 - pos;
				k.lit = d.s_units[off[1:0]];
			end
			5'd8, 5'd9, 5'd18, 5'd19: begin
				k.colon = 1'b1;
			end
			default: begin
				k = '0;
			end
		endcase
		return k;
	endfunction

endpackage

// File: sv/bcd_clock_pixel_frame.sv
// Pixel beats start once the request has been reduced to digits and queued,
// then one pixel beat per cycle while the sink is ready (28 beats per frame).
// Each request yields one frame of 28 pixel beats; the front reduces the next
// request meanwhile, and a two-entry digit queue lets it run ahead.
// Reset (arst_n low): stored time and both colour registers clear to zero,
// queue and output register empty.
// ----------------------------------------------------------------------------
// bcd_clock_pixel_frame
// Turns an epoch time into a 28-pixel BCD clock frame in snaking strip order.
// ----------------------------------------------------------------------------
module bcd_clock_pixel_frame (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
	input  logic        s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [4:0] pixel_index, [28:5] pixel_value, zero above
	output logic        m_axis_tlast,   // frame_end
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);
	import bcdcpf_pkg::*;

	logic [COLOUR_W-1:0] digit_colour_q;
	logic [COLOUR_W-1:0] colon_colour_q;

	logic    push;
	digits_t push_digits;
	logic    q_full;
	logic    pop;
	logic    head_valid;
	digits_t head_digits;

	logic [IDX_W-1:0]    out_index;
	logic [COLOUR_W-1:0] out_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_colour_q <= '0;
			colon_colour_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIGIT_COLOUR: digit_colour_q <= cfg_data;
				CFG_COLON_COLOUR: colon_colour_q <= cfg_data;
				default:          digit_colour_q <= digit_colour_q;
			endcase
		end
	end

	bcdcpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_kind     (s_axis_tuser),
		.in_time     (s_axis_tdata),
		.push        (push),
		.push_digits (push_digits),
		.q_full      (q_full)
	);

	bcdcpf_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_digits (push_digits),
		.full        (q_full),
		.pop         (pop),
		.head_valid  (head_valid),
		.head_digits (head_digits)
	);

	bcdcpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_digits  (head_digits),
		.pop          (pop),
		.digit_colour (digit_colour_q),
		.colon_colour (colon_colour_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_index    (out_index),
		.out_value    (out_value),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_value, out_index};

endmodule

// File: sv/bcdcpf_front.sv
// ----------------------------------------------------------------------------
// bcdcpf_front
// Accepts time requests, keeps the last shown time and reduces it to six BCD
// digits by reciprocal multiplication, one reduction step a cycle.
// ----------------------------------------------------------------------------
module bcdcpf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_kind,
	input  logic [bcdcpf_pkg::TIME_W-1:0]  in_time,
	output logic                           push,
	output bcdcpf_pkg::digits_t            push_digits,
	input  logic                           q_full
);
	import bcdcpf_pkg::*;

	typedef enum logic [2:0] {
		P_DAY,
		P_TOD,
		P_HR,
		P_HR_REM,
		P_MIN,
		P_SEC,
		P_PUSH
	} phase_t;

	logic              busy_q;
	phase_t            phase_q;
	logic [TIME_W-1:0] rem_q;
	logic [15:0]       days_q;
	logic [4:0]        hrs_q;
	logic [5:0]        mins_q;
	logic [5:0]        secs_q;
	logic [TIME_W-1:0] last_time_q;

	logic              accept;
	logic [50:0]       day_prod;
	logic [32:0]       day_back;
	logic [26:0]       hr_prod;
	logic [16:0]       hr_back;
	logic [20:0]       min_prod;
	logic [11:0]       min_back;
	logic [7:0]        h_bcd;
	logic [7:0]        m_bcd;
	logic [7:0]        s_bcd;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// whole days, then hours, then minutes of what is left
	assign day_prod = 51'(rem_q[TIME_W-1:7]) * 51'(DAY_RECIP);
	assign day_back = 33'(days_q) * 33'(DAY_SECS);
	assign hr_prod  = 27'(rem_q[16:4]) * 27'(HOUR_RECIP);
	assign hr_back  = 17'(hrs_q) * 17'(HOUR_SECS);
	assign min_prod = 21'(rem_q[11:2]) * 21'(MIN_RECIP);
	assign min_back = 12'(mins_q) * 12'(MIN_SECS);

	assign h_bcd = to_bcd({1'b0, hrs_q});
	assign m_bcd = to_bcd(mins_q);
	assign s_bcd = to_bcd(secs_q);

	assign push = busy_q && (phase_q == P_PUSH) && !q_full;
	assign push_digits = '{
		h_tens:  h_bcd[7:4],
		h_units: h_bcd[3:0],
		m_tens:  m_bcd[7:4],
		m_units: m_bcd[3:0],
		s_tens:  s_bcd[7:4],
		s_units: s_bcd[3:0]
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= P_DAY;
			last_time_q <= '0;
		end else if (accept) begin
			busy_q  <= 1'b1;
			phase_q <= P_DAY;
			if (in_kind == REQ_SHOW) begin
				last_time_q <= in_time;
			end
		end else if (busy_q) begin
			case (phase_q)
				P_DAY:    phase_q <= P_TOD;
				P_TOD:    phase_q <= P_HR;
				P_HR:     phase_q <= P_HR_REM;
				P_HR_REM: phase_q <= P_MIN;
				P_MIN:    phase_q <= P_SEC;
				P_SEC:    phase_q <= P_PUSH;
				P_PUSH: begin
					// hold the digits until the queue has room
					if (!q_full) begin
						busy_q <= 1'b0;
					end
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= (in_kind == REQ_SHOW) ? in_time : last_time_q;
		end else if (busy_q) begin
			case (phase_q)
				P_DAY:    days_q <= day_prod[50:35];
				P_TOD:    rem_q  <= rem_q - day_back[TIME_W-1:0];
				P_HR:     hrs_q  <= hr_prod[25:21];
				P_HR_REM: rem_q  <= rem_q - TIME_W'(hr_back);
				P_MIN:    mins_q <= min_prod[19:14];
				P_SEC:    secs_q <= 6'(rem_q[11:0] - min_back);
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

	a_push_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> in_ready)
		else $error("front still busy after handing off digits");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (phase_q == P_PUSH) && q_full |=> busy_q)
		else $error("front dropped an item while the queue was full");

endmodule

// File: sv/bcdcpf_fifo.sv
// ----------------------------------------------------------------------------
// bcdcpf_fifo
// Two-entry queue of digit sets between the front and the pixel sequencer.
// ----------------------------------------------------------------------------
module bcdcpf_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bcdcpf_pkg::digits_t push_digits,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output bcdcpf_pkg::digits_t head_digits
);
	import bcdcpf_pkg::*;

	digits_t    mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full        = (count_q == 2'd2);
	assign head_valid  = (count_q != 2'd0);
	assign head_digits = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_digits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop) && (count_q != 2'd3))
		else $error("digit queue overflow");

endmodule

// File: sv/bcdcpf_back.sv
// ----------------------------------------------------------------------------
// bcdcpf_back
// Walks the 28 strip positions of the head digit set and drives one pixel
// beat per cycle, while the sink is ready, through an output register.
// ----------------------------------------------------------------------------
module bcdcpf_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  bcdcpf_pkg::digits_t              head_digits,
	output logic                             pop,
	input  logic [bcdcpf_pkg::COLOUR_W-1:0]  digit_colour,
	input  logic [bcdcpf_pkg::COLOUR_W-1:0]  colon_colour,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bcdcpf_pkg::IDX_W-1:0]     out_index,
	output logic [bcdcpf_pkg::COLOUR_W-1:0]  out_value,
	output logic                             out_last
);
	import bcdcpf_pkg::*;

	logic [IDX_W-1:0]    pos_q;
	logic                valid_q;
	logic [IDX_W-1:0]    index_q;
	logic [COLOUR_W-1:0] value_q;
	logic                last_q;

	logic                advance;
	logic                at_end;
	pix_kind_t           kind;
	logic [COLOUR_W-1:0] value_n;

	assign advance = head_valid && (!valid_q || out_ready);
	assign at_end  = (pos_q == LAST_IDX);
	assign pop     = advance && at_end;
	assign kind    = pixel_kind(pos_q, head_digits);
	assign value_n = kind.colon ? colon_colour : (kind.lit ? digit_colour : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
			pos_q   <= at_end ? '0 : pos_q + IDX_W'(1);
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			index_q <= pos_q;
			value_q <= value_n;
			last_q  <= at_end;
		end
	end

	assign out_valid = valid_q;
	assign out_index = index_q;
	assign out_value = value_q;
	assign out_last  = last_q;

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_index == LAST_IDX)
		else $error("frame end flagged on the wrong pixel");

	a_frame_runs_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
			out_valid && (out_index == $past(out_index) + IDX_W'(1)))
		else $error("pixel beats of a frame not contiguous");

endmodule

// File: test/bcd_clock_pixel_frame_check.sv
// ----------------------------------------------------------------------------
// bcd_clock_pixel_frame_check
// Watches the request, pixel and register write ports of the clock frame
// block, builds the expected 28-pixel frame for every accepted request and
// compares each pixel beat against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bcd_clock_pixel_frame_check
	import bcdcpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
	input  logic        s_axis_tuser,   // [0] req_type
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [4:0] pixel_index, [28:5] pixel_value, zero above
	input  logic        m_axis_tlast,   // frame_end
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned SECS_PER_HOUR = 3600;
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned DECIMAL       = 10;
	localparam int          REPORT_MAX    = 10;

	typedef struct packed {
		logic [IDX_W-1:0]    index;
		logic [COLOUR_W-1:0] colour;
		logic                frame_end;
	} pixel_t;

	pixel_t              pixel_q[$];
	logic [COLOUR_W-1:0] digit_col;
	logic [COLOUR_W-1:0] colon_col;
	logic [TIME_W-1:0]   shown_time;

	task automatic add_pixel(inout int unsigned pos, input logic [COLOUR_W-1:0] colour);
		pixel_t px;
		px.index     = IDX_W'(pos);
		px.colour    = colour;
		px.frame_end = (pos == PIXELS - 1);
		pixel_q.push_back(px);
		pos++;
	endtask

	// expand one time of day into the snaking strip order
	task automatic queue_frame(input logic [TIME_W-1:0] t);
		int unsigned tod, hh, mm, ss, pos, bit_sel;
		logic [3:0]  digit [6];
		bit          run_up [6];
		tod = t % SECS_PER_DAY;
		hh  = tod / SECS_PER_HOUR;
		mm  = (tod / SECS_PER_MIN) % SECS_PER_MIN;
		ss  = tod % SECS_PER_MIN;
		digit[0] = 4'(hh / DECIMAL);  run_up[0] = 1'b1;
		digit[1] = 4'(hh % DECIMAL);  run_up[1] = 1'b0;
		digit[2] = 4'(mm / DECIMAL);  run_up[2] = 1'b0;
		digit[3] = 4'(mm % DECIMAL);  run_up[3] = 1'b1;
		digit[4] = 4'(ss / DECIMAL);  run_up[4] = 1'b1;
		digit[5] = 4'(ss % DECIMAL);  run_up[5] = 1'b0;
		pos = 0;
		for (int g = 0; g < 6; g++) begin
			for (int k = 0; k < 4; k++) begin
				bit_sel = run_up[g] ? k : 3 - k;
				add_pixel(pos, digit[g][bit_sel] ? digit_col : '0);
			end
			// colon pair follows hours and minutes
			if (g == 1 || g == 3) begin
				add_pixel(pos, colon_col);
				add_pixel(pos, colon_col);
			end
		end
	endtask

	task automatic check_pixel();
		pixel_t              want;
		logic [IDX_W-1:0]    got_index;
		logic [COLOUR_W-1:0] got_colour;
		logic [2:0]          got_pad;
		got_index  = m_axis_tdata[IDX_W-1:0];
		got_colour = m_axis_tdata[IDX_W +: COLOUR_W];
		got_pad    = m_axis_tdata[31:IDX_W+COLOUR_W];
		if (pixel_q.size() == 0) begin
			errors++;
			if (errors <= REPORT_MAX)
				$display("%0t: unexpected pixel beat: index %0d colour %06h last %0b",
					$time, got_index, got_colour, m_axis_tlast);
		end else begin
			want = pixel_q.pop_front();
			if (got_index != want.index || got_colour != want.colour ||
					m_axis_tlast != want.frame_end || got_pad != '0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: pixel mismatch: expected index %0d colour %06h last %0b pad 0, got index %0d colour %06h last %0b pad %0h",
						$time, want.index, want.colour, want.frame_end,
						got_index, got_colour, m_axis_tlast, got_pad);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q.delete();
			digit_col  = '0;
			colon_col  = '0;
			shown_time = '0;
			errors     = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_DIGIT_COLOUR)
					digit_col = cfg_data;
				else if (cfg_index == CFG_COLON_COLOUR)
					colon_col = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				// redraw keeps the stored time
				if (s_axis_tuser == REQ_SHOW)
					shown_time = s_axis_tdata;
				queue_frame(shown_time);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_pixel();
			pending = pixel_q.size();
		end
	end

endmodule

// File: test/bcd_clock_pixel_frame_test.sv
// ----------------------------------------------------------------------------
// bcd_clock_pixel_frame_test
// Drives time and redraw requests with random gaps and sink stalls, changes
// the digit and colon colours between phases, and lets the frame checker
// compare every pixel beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bcd_clock_pixel_frame_test;
	import bcdcpf_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 600;
	localparam int SETTLE_WAIT  = 40;
	localparam int unsigned SECS_PER_DAY = 86400;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic [23:0] cfg_data      = '0;

	int errors;
	int pending;
	int quiet = 0;
	bit tx_gap_en   = 1'b1;
	bit rx_stall_en = 1'b1;
	bit rx_hold     = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bcd_clock_pixel_frame i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	bcd_clock_pixel_frame_check i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	// abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sink side: ready stretches, short stalls, and one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input logic kind, input logic [31:0] t);
		if (tx_gap_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= t;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// hold the source until every expected pixel has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_colours(input logic [23:0] digit_col, input logic [23:0] colon_col);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DIGIT_COLOUR;
		cfg_data  <= digit_col;
		@(posedge clk);
		cfg_index <= CFG_COLON_COLOUR;
		cfg_data  <= colon_col;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_epoch();
		int unsigned days;
		days = $urandom_range(0, 49709);
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $urandom_range(0, SECS_PER_DAY - 1);
			2:       return days * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 10, SECS_PER_DAY - 1);
			default: return days * SECS_PER_DAY + $urandom_range(0, 9);
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_request(REQ_REDRAW, $urandom);
			else
				send_request(REQ_SHOW, rand_epoch());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset colours, nothing shown yet
		send_request(REQ_REDRAW, 32'hFFFF_FFFF);
		drain();

		set_colours(24'hFF_FFFF, 24'h00_0000);
		send_request(REQ_REDRAW, 32'h1234_5678);   // still midnight
		send_request(REQ_SHOW, 32'd0);
		send_request(REQ_SHOW, 32'd86399);         // 23:59:59
		send_request(REQ_REDRAW, 32'd0);
		send_request(REQ_SHOW, 32'd86400);         // wraps to midnight
		send_request(REQ_SHOW, 32'hFFFF_FFFF);
		send_request(REQ_SHOW, 32'd45296);         // 12:34:56
		send_request(REQ_SHOW, 32'd67108);         // 18:38:28
		send_request(REQ_SHOW, 32'd36610);         // 10:10:10
		send_request(REQ_SHOW, 32'd25627);         // 07:07:07
		send_request(REQ_SHOW, 32'd72000);         // 20:00:00
		send_request(REQ_SHOW, 32'd4294944000 - 32'd1);
		send_request(REQ_REDRAW, 32'hFFFF_FFFF);
		drain();

		set_colours(24'h00_0000, 24'hFF_FFFF);
		send_request(REQ_SHOW, 32'd86399);
		send_request(REQ_SHOW, 32'd61);
		send_request(REQ_SHOW, 32'd3599);          // 00:59:59
		send_request(REQ_REDRAW, 32'd0);
		drain();

		set_colours(24'($urandom), 24'($urandom));
		send_random(40);
		drain();

		// fill the block while the sink holds off
		set_colours(24'($urandom), 24'($urandom));
		rx_hold   = 1'b1;
		tx_gap_en = 1'b0;
		send_random(10);
		tx_gap_en = 1'b1;
		send_random(30);
		drain();

		set_colours(24'hA5_A5A5, 24'h5A_5A5A);
		send_random(40);
		drain();

		tx_gap_en   = 1'b0;
		rx_stall_en = 1'b0;
		set_colours(24'($urandom), 24'($urandom));
		send_random(40);
		drain();

		repeat (SETTLE_WAIT) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
